/* rtl/scope_edge_trigger_search_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the edge trigger search core
// Same-cycle and next-cycle implication checks, sampled on the rising clock.
// ----------------------------------------------------------------------------
`ifndef SCOPE_EDGE_TRIGGER_SEARCH_CORE_ASSERT_SVH
`define SCOPE_EDGE_TRIGGER_SEARCH_CORE_ASSERT_SVH

`define SETRIG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define SETRIG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/setrig_pkg.sv */
// ----------------------------------------------------------------------------
// Edge trigger search package
// Shared codes, widths and the record passed from the classifier to the
// result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package setrig_pkg;

   localparam int IDX_MAX_BITS = 16;
   localparam int CNT_MAX_BITS = 17;
   localparam int EXT_BITS     = 18;
   localparam int LEVEL_BITS   = 12;
   localparam int WINDOW_BITS  = 13;
   localparam int HALF_BITS    = 12;
   localparam int OUT_IDX_BITS = 12;
   localparam int QUEUE_DEPTH  = 4;

   typedef enum logic [1:0] {
      MODE_RISING  = 2'd0,
      MODE_FALLING = 2'd1,
      MODE_EITHER  = 2'd2
   } trig_mode_type;

   typedef enum logic [1:0] {
      CSR_MODE   = 2'd0,
      CSR_LEVEL  = 2'd1,
      CSR_WINDOW = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                    cand;
      logic                    last;
      logic [IDX_MAX_BITS-1:0] idx;
      logic [CNT_MAX_BITS-1:0] count;
   } setrig_entry_type;

endpackage

`default_nettype wire

/* rtl/setrig_front.sv */
// ----------------------------------------------------------------------------
// Edge trigger search front end
// Takes samples, tracks the buffer position and marks each qualifying edge.
// ----------------------------------------------------------------------------
`default_nettype none

module setrig_front
   import setrig_pkg::*;
#(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [SAMPLE_BITS-1:0] in_sample,
   input  wire logic                   in_last,
   input  wire logic [1:0]             mode,
   input  wire logic [LEVEL_BITS-1:0]  level,
   input  wire logic [HALF_BITS-1:0]   half,
   output logic                        push_valid,
   input  wire logic                   push_ready,
   output setrig_entry_type            push_entry
);

   localparam int IW    = $clog2(MAX_SAMPLES);
   localparam int CW    = IW + 1;
   localparam int CMP_W = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;

   logic [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          count_next;
   logic [IW-1:0]          pos;
   logic [CMP_W-1:0]       prev_x, cur_x, level_x;
   logic                   rising, falling, is_edge, in_range, cand, accept;

   assign in_ready   = push_ready;
   assign push_valid = in_valid;
   assign accept     = in_valid && push_ready;

   assign in_range   = count_ff < CW'(MAX_SAMPLES);
   assign pos        = count_ff[IW-1:0] - 1'b1;
   assign count_next = in_range ? count_ff + 1'b1 : count_ff;

   assign prev_x  = CMP_W'(prev_ff);
   assign cur_x   = CMP_W'(in_sample);
   assign level_x = CMP_W'(level);
   assign rising  = (prev_x < level_x) && (cur_x >= level_x);
   assign falling = (prev_x > level_x) && (cur_x <= level_x);

   always_comb begin
      unique case (mode)
         MODE_RISING:  is_edge = rising;
         MODE_FALLING: is_edge = falling;
         MODE_EITHER:  is_edge = rising || falling;
         default:      is_edge = 1'b0;
      endcase
   end

   assign cand = in_range && (count_ff != '0) && is_edge
              && (EXT_BITS'(pos) >= EXT_BITS'(half));

   always_comb begin
      push_entry.cand  = cand;
      push_entry.last  = in_last;
      push_entry.idx   = IDX_MAX_BITS'(pos);
      push_entry.count = CNT_MAX_BITS'(count_next);
   end

   always_comb begin
      prev_in  = prev_ff;
      count_in = count_ff;
      if (accept) begin
         if (in_last) begin
            prev_in  = '0;
            count_in = '0;
         end else begin
            if (in_range) begin
               prev_in = in_sample;
            end
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         count_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/setrig_queue.sv */
// ----------------------------------------------------------------------------
// Edge trigger search queue
// Small first-in first-out buffer between the front end and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module setrig_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = fill_ff != NW'(DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/setrig_back.sv */
// ----------------------------------------------------------------------------
// Edge trigger search result stage
// Keeps the first marked edge of a buffer and forms the result at its end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scope_edge_trigger_search_core_assert.svh"

module setrig_back
   import setrig_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pop_valid,
   output logic                        pop_ready,
   input  wire setrig_entry_type       pop_entry,
   input  wire logic [HALF_BITS-1:0]   half,
   input  wire logic [WINDOW_BITS-1:0] window,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic                        out_found,
   output logic [OUT_IDX_BITS-1:0]     out_edge_index,
   output logic [OUT_IDX_BITS-1:0]     out_window_start,
   output logic [WINDOW_BITS-1:0]      out_record_length
);

   logic                    hit_ff, hit_in;
   logic [IDX_MAX_BITS-1:0] pos_ff, pos_in;
   logic                    valid_ff, valid_in;
   logic                    found_ff, found_in;
   logic [OUT_IDX_BITS-1:0] idx_ff, idx_in;
   logic [OUT_IDX_BITS-1:0] ws_ff, ws_in;
   logic [WINDOW_BITS-1:0]  rlen_ff, rlen_in;
   logic                    pop, hit_now, found;
   logic [IDX_MAX_BITS-1:0] pos_now, ws_full;
   logic [EXT_BITS-1:0]     reach;

   assign pop       = pop_valid && (!valid_ff || out_ready);
   assign pop_ready = !valid_ff || out_ready;

   assign hit_now = hit_ff || pop_entry.cand;
   assign pos_now = hit_ff ? pos_ff : pop_entry.idx;
   assign reach   = EXT_BITS'(pos_now) + EXT_BITS'(half);
   assign found   = hit_now && (reach < EXT_BITS'(pop_entry.count));
   assign ws_full = pos_now - IDX_MAX_BITS'(half);

   always_comb begin
      hit_in   = hit_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff;
      found_in = found_ff;
      idx_in   = idx_ff;
      ws_in    = ws_ff;
      rlen_in  = rlen_ff;
      if (valid_ff && out_ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         if (pop_entry.last) begin
            hit_in   = 1'b0;
            pos_in   = '0;
            valid_in = 1'b1;
            found_in = found;
            idx_in   = found ? pos_now[OUT_IDX_BITS-1:0] : '0;
            ws_in    = found ? ws_full[OUT_IDX_BITS-1:0] : '0;
            rlen_in  = window;
         end else if (!hit_ff && pop_entry.cand) begin
            hit_in = 1'b1;
            pos_in = pop_entry.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      found_ff <= found_in;
      idx_ff   <= idx_in;
      ws_ff    <= ws_in;
      rlen_ff  <= rlen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         hit_ff   <= hit_in;
         valid_ff <= valid_in;
      end
   end

   assign out_valid         = valid_ff;
   assign out_found         = found_ff;
   assign out_edge_index    = idx_ff;
   assign out_window_start  = ws_ff;
   assign out_record_length = rlen_ff;

   `SETRIG_ASSERT_NOW(a_miss_zero, clock, reset, valid_ff && !found_ff,
      (idx_ff == '0) && (ws_ff == '0), "result without a trigger carries a position")
   `SETRIG_ASSERT_NEXT(a_clear_on_last, clock, reset, pop && pop_entry.last,
      !hit_ff, "edge state not cleared after the end of a buffer")
   `SETRIG_ASSERT_NEXT(a_hit_kept, clock, reset, hit_ff && !(pop && pop_entry.last),
      hit_ff && $stable(pos_ff), "first edge lost or overwritten within a buffer")

endmodule

`default_nettype wire

/* rtl/scope_edge_trigger_search_core.sv */
// ----------------------------------------------------------------------------
// Oscilloscope edge trigger search core
// Finds the first level crossing in a captured buffer and reports its
// position and display window at the end of the buffer.
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle for as long as the result side keeps
// up; the front end compares each sample combinationally with its
// predecessor, and a four-entry queue decouples it from the result stage,
// so a result waiting on rsp_tready stalls the input only once the queue
// fills. With the queue empty and no earlier result waiting, the result
// is presented on rsp once the req_tlast entry has left the queue and been
// registered. Configuration writes are always accepted and take effect
// from the next sample; they are to be made only while no sample is in
// flight, as a queued buffer end is finished with the current settings.
`default_nettype none

module scope_edge_trigger_search_core
   import setrig_pkg::*;
#(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // tdata: sample [SAMPLE_BITS-1:0], zero padding above
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   input  wire logic                                req_tlast,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata: edge_index [11:0], window_start [23:12], record_length [36:24],
   // zero padding [39:37]
   output logic [39:0]                              rsp_tdata,
   // tuser: found [0]
   output logic                                     rsp_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [1:0]                          csr_index,
   input  wire logic [WINDOW_BITS-1:0]              csr_data
);

   logic [1:0]              mode_ff, mode_in;
   logic [LEVEL_BITS-1:0]   level_ff, level_in;
   logic [WINDOW_BITS-1:0]  window_ff, window_in;
   logic [HALF_BITS-1:0]    half;
   logic                    push_valid, push_ready, pop_valid, pop_ready;
   setrig_entry_type        push_entry, pop_entry;
   logic [OUT_IDX_BITS-1:0] edge_index, window_start;
   logic [WINDOW_BITS-1:0]  record_length;

   assign csr_ready = 1'b1;
   assign half      = window_ff[WINDOW_BITS-1:1];

   always_comb begin
      mode_in   = mode_ff;
      level_in  = level_ff;
      window_in = window_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:   mode_in   = csr_data[1:0];
            CSR_LEVEL:  level_in  = csr_data[LEVEL_BITS-1:0];
            CSR_WINDOW: window_in = csr_data;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RISING;
         level_ff  <= '0;
         window_ff <= WINDOW_BITS'(240);
      end else begin
         mode_ff   <= mode_in;
         level_ff  <= level_in;
         window_ff <= window_in;
      end
   end

   setrig_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .in_last    (req_tlast),
      .mode       (mode_ff),
      .level      (level_ff),
      .half       (half),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   setrig_queue #(
      .WIDTH ($bits(setrig_entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_entry)
   );

   setrig_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_entry         (pop_entry),
      .half              (half),
      .window            (window_ff),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .out_found         (rsp_tuser),
      .out_edge_index    (edge_index),
      .out_window_start  (window_start),
      .out_record_length (record_length)
   );

   assign rsp_tdata = {3'b000, record_length, window_start, edge_index};

endmodule

`default_nettype wire
